@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mprtd_pkg.sv @@
// Package for the multidrop packet receiver with tally decode.
// Types, codes and constants; no dependencies.
package mprtd_pkg;

	localparam int KEPT_BYTES    = 3;
	localparam int MAX_CHANNEL   = 8;
	localparam int CHANNEL_LIMIT = 9;
	localparam int CNT_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_FRAMING   = 3'd1,
		ERR_OVERRUN   = 3'd2,
		ERR_PARITY    = 3'd3,
		ERR_UNDERFLOW = 3'd4,
		ERR_BAD_STATE = 3'd5,
		ERR_UNKNOWN   = 3'd6
	} err_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_ADDR  = 2'd0,
		CFG_BCAST_ADDR = 2'd1,
		CFG_SET_CH_OP  = 2'd2,
		CFG_TALLY_OP   = 2'd3
	} cfg_reg_t;

endpackage

@@ rtl/mprtd_in_if.sv @@
// Input channel: one received 9-bit character with line fault flags.
// Depends on nothing.
interface mprtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       address_flag;
	logic       framing_fault;
	logic       overrun_fault;
	logic       parity_fault;

	modport source (output valid, rx_byte, address_flag, framing_fault, overrun_fault,
		parity_fault, input ready);
	modport sink (input valid, rx_byte, address_flag, framing_fault, overrun_fault,
		parity_fault, output ready);
endinterface

@@ rtl/mprtd_out_if.sv @@
// Output channel: lamp drives, channel and per-character status.
// Depends on mprtd_pkg.
interface mprtd_out_if import mprtd_pkg::*;;
	logic       valid;
	logic       ready;
	logic       program_lamp;
	logic       preview_lamp;
	logic [3:0] channel;
	logic       save_pulse;
	logic       packet_done;
	err_code_t  error_code;

	modport source (output valid, program_lamp, preview_lamp, channel, save_pulse,
		packet_done, error_code, input ready);
	modport sink (input valid, program_lamp, preview_lamp, channel, save_pulse,
		packet_done, error_code, output ready);
endinterface

@@ rtl/multidrop_packet_receiver_tally_decode.sv @@
// Top level: 9-bit multidrop address filter, packet assembly and tally decode.
// Depends on mprtd_pkg, mprtd_in_if, mprtd_out_if and assert_macros.svh.
//
// Usage:
//  in_ch  - one received character per transaction (data, address bit, faults).
//  out_ch - one result per character: lamp drives, channel, save pulse,
//           packet done and error code.
//  cfg_*  - register writes (node address, broadcast address, two opcodes),
//           taken on any edge with cfg_we high; write only while idle.
// Pipeline: a character accepted into the input register gives its result in
//  the result register (valid on out_ch there), two register stages in all.
// Throughput: one character per cycle while out_ch accepts results. The decode
//  state (packet counters, kept bytes, channel, lamps) is updated from the input
//  register in the same cycle as the result register is loaded, so the next character sees it.
// Stall: when out_ch is not ready the result register holds; the input
//  register takes one more character only if it is empty, then in_ch.ready drops.
// Reset: arst_n clears both stages, listens for addresses only, channel 0,
//  lamps dark, registers back to their defaults. Kept bytes are not cleared.
`include "assert_macros.svh"

module multidrop_packet_receiver_tally_decode import mprtd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mprtd_in_if.sink              in_ch,
	mprtd_out_if.source           out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration
	logic [6:0] node_address_q;
	logic [7:0] broadcast_address_q;
	logic [7:0] set_channel_opcode_q;
	logic [7:0] tally_opcode_q;

	// input stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       address_flag_s1;
	logic       framing_s1;
	logic       overrun_s1;
	logic       parity_s1;

	// decode state
	logic             address_only_q;
	logic             receiving_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       packet_length_q;
	logic [7:0]       packet_bytes_q [KEPT_BYTES];
	logic [3:0]       tally_channel_q;
	logic             program_on_q;
	logic             preview_on_q;

	// result stage
	logic       valid_s2;
	logic       program_s2;
	logic       preview_s2;
	logic [3:0] channel_s2;
	logic       save_s2;
	logic       done_s2;
	err_code_t  err_s2;

	// next-state logic
	logic             advance;
	logic             in_accept;
	logic             fault;
	logic             data_taken;
	logic [CNT_W-1:0] byte_idx;
	logic             pb_wr;
	logic [7:0]       pb_next [KEPT_BYTES];
	logic             address_only_d;
	logic             receiving_d;
	logic [CNT_W-1:0] byte_count_d;
	logic [7:0]       packet_length_d;
	logic [3:0]       tally_channel_d;
	logic             program_d;
	logic             preview_d;
	logic             save_d;
	logic             done_d;
	err_code_t        err_d;
	logic [2:0]       lamp_bit;

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_accept    = in_ch.valid && in_ch.ready;

	assign fault      = framing_s1 || overrun_s1 || parity_s1;
	assign data_taken = !fault && !address_flag_s1 && !address_only_q;
	assign byte_idx   = byte_count_q - CNT_W'(1);
	assign pb_wr      = data_taken && (byte_count_q != '0) && (byte_idx < CNT_W'(KEPT_BYTES));
	assign lamp_bit   = 3'(tally_channel_q - 4'd1);

	always_comb begin
		for (int k = 0; k < KEPT_BYTES; k++) begin
			pb_next[k] = (pb_wr && byte_idx == CNT_W'(k)) ? rx_byte_s1 : packet_bytes_q[k];
		end
	end

	always_comb begin
		address_only_d  = address_only_q;
		receiving_d     = receiving_q;
		byte_count_d    = byte_count_q;
		packet_length_d = packet_length_q;
		tally_channel_d = tally_channel_q;
		program_d       = program_on_q;
		preview_d       = preview_on_q;
		save_d          = 1'b0;
		done_d          = 1'b0;
		err_d           = ERR_NONE;
		if (fault) begin
			// parity over overrun over framing, no state change
			if (parity_s1) begin
				err_d = ERR_PARITY;
			end else if (overrun_s1) begin
				err_d = ERR_OVERRUN;
			end else begin
				err_d = ERR_FRAMING;
			end
		end else if (address_flag_s1) begin
			if (rx_byte_s1 == broadcast_address_q || rx_byte_s1 == {1'b0, node_address_q}) begin
				if (receiving_q) begin
					err_d = ERR_UNDERFLOW;
				end
				byte_count_d   = '0;
				receiving_d    = 1'b1;
				address_only_d = 1'b0;
			end
		end else if (data_taken) begin
			if (!receiving_q) begin
				err_d = ERR_BAD_STATE;
			end
			if (byte_count_q == '0) begin
				packet_length_d = rx_byte_s1;
			end
			if (byte_count_q != '1) begin
				byte_count_d = byte_count_q + CNT_W'(1);
			end
			if (byte_count_d > CNT_W'(packet_length_d)) begin
				address_only_d = 1'b1;
				receiving_d    = 1'b0;
				done_d         = 1'b1;
				// execute command; set-channel takes priority on equal opcodes
				if (pb_next[0] == set_channel_opcode_q) begin
					if (node_address_q <= 7'(MAX_CHANNEL)) begin
						if (pb_next[1] < 8'(CHANNEL_LIMIT)) begin
							tally_channel_d = pb_next[1][3:0];
						end
						save_d = 1'b1;
					end
				end else if (pb_next[0] == tally_opcode_q) begin
					program_d = 1'b0;
					preview_d = 1'b0;
					if (tally_channel_q != 4'd0 && tally_channel_q <= 4'(MAX_CHANNEL)) begin
						program_d = pb_next[1][lamp_bit];
						preview_d = pb_next[2][lamp_bit];
					end
				end else begin
					err_d = ERR_UNKNOWN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q       <= 7'd8;
			broadcast_address_q  <= 8'd0;
			set_channel_opcode_q <= 8'd1;
			tally_opcode_q       <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NODE_ADDR:  node_address_q       <= cfg_wdata[6:0];
				CFG_BCAST_ADDR: broadcast_address_q  <= cfg_wdata;
				CFG_SET_CH_OP:  set_channel_opcode_q <= cfg_wdata;
				CFG_TALLY_OP:   tally_opcode_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1      <= in_ch.rx_byte;
			address_flag_s1 <= in_ch.address_flag;
			framing_s1      <= in_ch.framing_fault;
			overrun_s1      <= in_ch.overrun_fault;
			parity_s1       <= in_ch.parity_fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_only_q  <= 1'b1;
			receiving_q     <= 1'b0;
			byte_count_q    <= '0;
			packet_length_q <= '0;
			tally_channel_q <= '0;
			program_on_q    <= 1'b0;
			preview_on_q    <= 1'b0;
		end else if (advance) begin
			address_only_q  <= address_only_d;
			receiving_q     <= receiving_d;
			byte_count_q    <= byte_count_d;
			packet_length_q <= packet_length_d;
			tally_channel_q <= tally_channel_d;
			program_on_q    <= program_d;
			preview_on_q    <= preview_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < KEPT_BYTES; k++) begin
				packet_bytes_q[k] <= pb_next[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			program_s2 <= program_d;
			preview_s2 <= preview_d;
			channel_s2 <= tally_channel_d;
			save_s2    <= save_d;
			done_s2    <= done_d;
			err_s2     <= err_d;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.program_lamp = program_s2;
	assign out_ch.preview_lamp = preview_s2;
	assign out_ch.channel      = channel_s2;
	assign out_ch.save_pulse   = save_s2;
	assign out_ch.packet_done  = done_s2;
	assign out_ch.error_code   = err_s2;

	`ASSERT_ALWAYS(a_open_flags, receiving_q != address_only_q, "packet open flags disagree")
	`ASSERT_ALWAYS(a_channel_range, tally_channel_q <= 4'(MAX_CHANNEL), "tally channel out of range")
	`ASSERT_NEXT(a_done_closes, advance && done_d, !receiving_q && address_only_q, "packet left open after completion")
	`ASSERT_NEXT(a_fault_no_change, advance && fault, $stable(receiving_q) && $stable(byte_count_q) && $stable(tally_channel_q), "faulted character changed state")
	`ASSERT_IMPL(a_save_with_done, valid_s2 && save_s2, done_s2, "save pulse without packet completion")

endmodule
